[rtl/core/gji_pkg.sv]
// Package for the Gauss-Jordan matrix inverse unit.
// Holds the sizes, codes, command and status types and the Q16.16 saturation functions.
// It depends on nothing else.
`timescale 1ns / 1ps

package gji_pkg;

    localparam int MAX_ORDER = 8;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int SIZE_W    = 4;
    localparam int MEM_DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int DATA_W    = 32;
    localparam int QUO_W     = 48;
    localparam int PROD_W    = 64;

    localparam logic signed [DATA_W-1:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh80000000;

    typedef enum logic [1:0] {
        WSEL_LOAD,
        WSEL_IDENT,
        WSEL_DIV,
        WSEL_SUB
    } wsel_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_INIT,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SW0,
        ST_SW1,
        ST_SW2,
        ST_N_RD,
        ST_N_LAT,
        ST_N_SW,
        ST_N_WW,
        ST_N_WI,
        ST_E_CHK,
        ST_E_FR,
        ST_E_FL,
        ST_E_RA,
        ST_E_RB,
        ST_E_M1,
        ST_E_M2,
        ST_E_W1,
        ST_E_W2,
        ST_KNEXT,
        ST_O_RD,
        ST_O_EM,
        ST_SING
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             we_w;
        logic             we_i;
        wsel_t            wsel;
        logic             perm_init;
        logic             perm_xchg;
        logic             lat_piv;
        logic             lat_f;
        logic             lat_a;
        logic             lat_b;
        logic             mul_sel;
        logic             div_start;
        logic             div_sel;
        logic             emit;
        logic             emit_last;
        logic             emit_sing;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_nonzero;
        logic div_busy;
    } dp_sts_t;

    function automatic logic signed [DATA_W-1:0] sat_mul(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        logic signed [QUO_W-1:0]  q;
        t = p + (p[PROD_W-1] ? 64'sd65535 : 64'sd0);
        q = t[PROD_W-1:16];
        if (q > 48'sd2147483647) begin
            return Q_MAX;
        end
        else if (q < -48'sd2147483648) begin
            return Q_MIN;
        end
        return q[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] d;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d[DATA_W] != d[DATA_W-1]) begin
            return d[DATA_W] ? Q_MIN : Q_MAX;
        end
        return d[DATA_W-1:0];
    endfunction

endpackage

[rtl/core/gauss_jordan_matrix_inverse_unit.sv]
// Top level of the Gauss-Jordan matrix inverse unit: controller plus datapath.
// Depends on gji_pkg, gji_ctrl and gji_datapath.
//
// The unit takes one Q16.16 element per cycle while busy is low, row-major, for an
// n-by-n matrix where n is the matrix_size register (0 counts as 1, above 8 as 8).
// The beat holding the last element starts the inversion. Busy stays high until the
// cycle that carries the last result beat. Results come out one per strobe cycle with
// no backpressure, so the receiver must take every beat on result_valid. A singular
// matrix gives a single beat with singular and is_last set. The inversion runs on one
// shared divider and one multiplier. Each pivot is checked, its row normalized and the
// other rows eliminated. A zero pivot starts a search of the rows below it for a nonzero
// entry, then a row exchange. A full run goes through load, setup, the pivots and output.
`timescale 1ns / 1ps

module gauss_jordan_matrix_inverse_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [gji_pkg::DATA_W-1:0] element_value,
    input  logic                              cfg_write,
    input  logic [gji_pkg::SIZE_W-1:0]        cfg_data,
    output logic                              result_valid,
    output logic signed [gji_pkg::DATA_W-1:0] result_value,
    output logic                              is_last,
    output logic                              singular
);

    gji_pkg::dp_cmd_t cmd;
    gji_pkg::dp_sts_t sts;

    gji_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cfg_write(cfg_write),
        .cfg_data (cfg_data),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    gji_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .element_value(element_value),
        .sts          (sts),
        .result_valid (result_valid),
        .result_value (result_value),
        .is_last      (is_last),
        .singular     (singular)
    );

endmodule

[rtl/core/gji_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps

module gji_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gji_div.sv]
// Iterative Q16.16 divider: saturated (a * 65536) / p, truncated toward zero.
// One quotient bit per cycle. Depends on gji_pkg.
`timescale 1ns / 1ps

module gji_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [gji_pkg::DATA_W-1:0] dividend,
    input  logic signed [gji_pkg::DATA_W-1:0] divisor,
    output logic                            busy,
    output logic signed [gji_pkg::DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(gji_pkg::QUO_W + 1);

    logic [gji_pkg::QUO_W-1:0]  num_reg;
    logic [gji_pkg::DATA_W-1:0] den_reg;
    logic [gji_pkg::DATA_W-1:0] rem_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       neg_reg;
    logic                       busy_reg;

    logic [gji_pkg::DATA_W:0]   mag_a;
    logic [gji_pkg::DATA_W:0]   mag_p;
    logic [gji_pkg::DATA_W:0]   rem_sh;
    logic [gji_pkg::DATA_W:0]   rem_dif;
    logic                       ge;
    logic [gji_pkg::DATA_W-1:0] neg_q;

    always_comb
    begin
        mag_a = dividend[gji_pkg::DATA_W-1] ?
                ((gji_pkg::DATA_W+1)'(0) - {dividend[gji_pkg::DATA_W-1], dividend}) :
                {1'b0, dividend};
        mag_p = divisor[gji_pkg::DATA_W-1] ?
                ((gji_pkg::DATA_W+1)'(0) - {divisor[gji_pkg::DATA_W-1], divisor}) :
                {1'b0, divisor};
        rem_sh  = {rem_reg, num_reg[gji_pkg::QUO_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_dif = rem_sh - {1'b0, den_reg};
        neg_q   = gji_pkg::DATA_W'(0) - num_reg[gji_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(gji_pkg::QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {mag_a[gji_pkg::DATA_W-1:0], 16'd0};
            den_reg <= mag_p[gji_pkg::DATA_W-1:0];
            rem_reg <= '0;
            neg_reg <= dividend[gji_pkg::DATA_W-1] ^ divisor[gji_pkg::DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_dif[gji_pkg::DATA_W-1:0] : rem_sh[gji_pkg::DATA_W-1:0];
            num_reg <= {num_reg[gji_pkg::QUO_W-2:0], ge};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (num_reg > gji_pkg::QUO_W'(48'h80000000)) ? gji_pkg::Q_MIN : neg_q;
        end
        else
        begin
            quotient = (num_reg > gji_pkg::QUO_W'(48'h7FFFFFFF)) ?
                       gji_pkg::Q_MAX : num_reg[gji_pkg::DATA_W-1:0];
        end
    end

    assign busy = busy_reg;

endmodule

[rtl/core/gji_datapath.sv]
// Datapath of the inverse unit: matrix RAMs, row map, multiplier, divider and result registers.
// Depends on gji_pkg, gji_ram and gji_div.
`timescale 1ns / 1ps

module gji_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gji_pkg::dp_cmd_t                  cmd,
    input  logic signed [gji_pkg::DATA_W-1:0] element_value,
    output gji_pkg::dp_sts_t                  sts,
    output logic                              result_valid,
    output logic signed [gji_pkg::DATA_W-1:0] result_value,
    output logic                              is_last,
    output logic                              singular
);

    logic [gji_pkg::IDX_W-1:0] perm_reg [gji_pkg::MAX_ORDER];
    logic [gji_pkg::IDX_W-1:0] sw_reg;
    logic [gji_pkg::IDX_W-1:0] perm_row;
    logic [gji_pkg::ADDR_W-1:0] addr;

    logic signed [gji_pkg::DATA_W-1:0] rd_w;
    logic signed [gji_pkg::DATA_W-1:0] rd_i;
    logic signed [gji_pkg::DATA_W-1:0] wdata_w;
    logic signed [gji_pkg::DATA_W-1:0] wdata_i;

    logic signed [gji_pkg::DATA_W-1:0] piv_reg;
    logic signed [gji_pkg::DATA_W-1:0] f_reg;
    logic signed [gji_pkg::DATA_W-1:0] aw_reg;
    logic signed [gji_pkg::DATA_W-1:0] ai_reg;
    logic signed [gji_pkg::DATA_W-1:0] bw_reg;
    logic signed [gji_pkg::DATA_W-1:0] bi_reg;
    logic signed [gji_pkg::PROD_W-1:0] prod_reg;
    logic signed [gji_pkg::DATA_W-1:0] mq_reg;

    logic signed [gji_pkg::DATA_W-1:0] div_q;
    logic                              div_busy;

    logic                              result_valid_reg;
    logic signed [gji_pkg::DATA_W-1:0] result_value_reg;
    logic                              is_last_reg;
    logic                              singular_reg;

    assign perm_row = perm_reg[cmd.row];
    assign addr     = {perm_row, cmd.col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int x = 0; x < gji_pkg::MAX_ORDER; x++)
            begin
                perm_reg[x] <= gji_pkg::IDX_W'(x);
            end
            sw_reg <= '0;
        end
        else if (cmd.perm_init)
        begin
            for (int x = 0; x < gji_pkg::MAX_ORDER; x++)
            begin
                perm_reg[x] <= gji_pkg::IDX_W'(x);
            end
        end
        else if (cmd.perm_xchg)
        begin
            perm_reg[cmd.row] <= sw_reg;
            sw_reg            <= perm_row;
        end
    end

    always_comb
    begin
        wdata_w = gji_pkg::sat_sub(bw_reg, mq_reg);
        wdata_i = gji_pkg::sat_sub(bi_reg, mq_reg);
        case (cmd.wsel)
            gji_pkg::WSEL_LOAD:
            begin
                wdata_w = element_value;
                wdata_i = '0;
            end
            gji_pkg::WSEL_IDENT:
            begin
                wdata_w = '0;
                wdata_i = (cmd.row == cmd.col) ? gji_pkg::ONE_Q16 : '0;
            end
            gji_pkg::WSEL_DIV:
            begin
                wdata_w = div_q;
                wdata_i = div_q;
            end
            default:
            begin
                wdata_w = gji_pkg::sat_sub(bw_reg, mq_reg);
                wdata_i = gji_pkg::sat_sub(bi_reg, mq_reg);
            end
        endcase
    end

    gji_ram #(
        .WIDTH(gji_pkg::DATA_W),
        .DEPTH(gji_pkg::MEM_DEPTH)
    ) u_work_ram (
        .clk  (clk),
        .we   (cmd.we_w),
        .waddr(addr),
        .wdata(wdata_w),
        .raddr(addr),
        .rdata(rd_w)
    );

    gji_ram #(
        .WIDTH(gji_pkg::DATA_W),
        .DEPTH(gji_pkg::MEM_DEPTH)
    ) u_inv_ram (
        .clk  (clk),
        .we   (cmd.we_i),
        .waddr(addr),
        .wdata(wdata_i),
        .raddr(addr),
        .rdata(rd_i)
    );

    gji_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(cmd.div_sel ? ai_reg : aw_reg),
        .divisor (piv_reg),
        .busy    (div_busy),
        .quotient(div_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.lat_piv)
        begin
            piv_reg <= rd_w;
        end
        if (cmd.lat_f)
        begin
            f_reg <= rd_w;
        end
        if (cmd.lat_a)
        begin
            aw_reg <= rd_w;
            ai_reg <= rd_i;
        end
        if (cmd.lat_b)
        begin
            bw_reg <= rd_w;
            bi_reg <= rd_i;
        end
        prod_reg         <= (cmd.mul_sel ? ai_reg : aw_reg) * f_reg;
        mq_reg           <= gji_pkg::sat_mul(prod_reg);
        result_value_reg <= cmd.emit_sing ? '0 : rd_i;
        is_last_reg      <= cmd.emit_sing | cmd.emit_last;
        singular_reg     <= cmd.emit_sing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit | cmd.emit_sing;
        end
    end

    assign sts.rd_nonzero = (rd_w != '0);
    assign sts.div_busy   = div_busy;

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign is_last      = is_last_reg;
    assign singular     = singular_reg;

endmodule

[rtl/core/gji_ctrl.sv]
// Controller of the inverse unit: load, identity setup, pivot search, normalize, eliminate and output sequencing.
// Depends on gji_pkg.
`timescale 1ns / 1ps

module gji_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              cfg_write,
    input  logic [gji_pkg::SIZE_W-1:0]        cfg_data,
    input  gji_pkg::dp_sts_t                  sts,
    output gji_pkg::dp_cmd_t                  cmd,
    output logic                              busy
);

    gji_pkg::state_t state_reg, state_next;
    logic [gji_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [gji_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [gji_pkg::IDX_W-1:0]  j_reg, j_next;
    logic [gji_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [gji_pkg::IDX_W-1:0]  r_reg, r_next;
    logic [gji_pkg::SIZE_W-1:0] n_eff;
    logic [gji_pkg::SIZE_W-1:0] n_m1;
    logic [gji_pkg::IDX_W-1:0]  nm1;
    logic                       j_end;
    logic                       i_end;

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = gji_pkg::SIZE_W'(1);
        end
        else if (size_reg > gji_pkg::SIZE_W'(gji_pkg::MAX_ORDER))
        begin
            n_eff = gji_pkg::SIZE_W'(gji_pkg::MAX_ORDER);
        end
        else
        begin
            n_eff = size_reg;
        end
        n_m1  = n_eff - 1'b1;
        nm1   = n_m1[gji_pkg::IDX_W-1:0];
        j_end = (j_reg == nm1);
        i_end = (i_reg == nm1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gji_pkg::ST_LOAD;
            size_reg  <= gji_pkg::SIZE_W'(gji_pkg::MAX_ORDER);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        unique case (state_reg)
            gji_pkg::ST_LOAD:
            begin
                if (cfg_write)
                begin
                    size_next = cfg_data;
                    i_next    = '0;
                    j_next    = '0;
                end
                else if (start)
                begin
                    if (j_end)
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            i_next     = '0;
                            state_next = gji_pkg::ST_INIT;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            gji_pkg::ST_INIT:
            begin
                if (j_end)
                begin
                    j_next = '0;
                    if (i_end)
                    begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = gji_pkg::ST_PIV_RD;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            gji_pkg::ST_PIV_RD:
            begin
                state_next = gji_pkg::ST_PIV_CHK;
            end
            gji_pkg::ST_PIV_CHK:
            begin
                if (sts.rd_nonzero)
                begin
                    j_next     = '0;
                    state_next = gji_pkg::ST_N_RD;
                end
                else if (k_reg == nm1)
                begin
                    state_next = gji_pkg::ST_SING;
                end
                else
                begin
                    r_next     = k_reg + 1'b1;
                    state_next = gji_pkg::ST_SRCH_RD;
                end
            end
            gji_pkg::ST_SRCH_RD:
            begin
                state_next = gji_pkg::ST_SRCH_CHK;
            end
            gji_pkg::ST_SRCH_CHK:
            begin
                if (sts.rd_nonzero)
                begin
                    state_next = gji_pkg::ST_SW0;
                end
                else if (r_reg == nm1)
                begin
                    state_next = gji_pkg::ST_SING;
                end
                else
                begin
                    r_next     = r_reg + 1'b1;
                    state_next = gji_pkg::ST_SRCH_RD;
                end
            end
            gji_pkg::ST_SW0:
            begin
                state_next = gji_pkg::ST_SW1;
            end
            gji_pkg::ST_SW1:
            begin
                state_next = gji_pkg::ST_SW2;
            end
            gji_pkg::ST_SW2:
            begin
                j_next     = '0;
                state_next = gji_pkg::ST_N_RD;
            end
            gji_pkg::ST_N_RD:
            begin
                state_next = gji_pkg::ST_N_LAT;
            end
            gji_pkg::ST_N_LAT:
            begin
                state_next = gji_pkg::ST_N_SW;
            end
            gji_pkg::ST_N_SW:
            begin
                state_next = gji_pkg::ST_N_WW;
            end
            gji_pkg::ST_N_WW:
            begin
                if (!sts.div_busy)
                begin
                    state_next = gji_pkg::ST_N_WI;
                end
            end
            gji_pkg::ST_N_WI:
            begin
                if (!sts.div_busy)
                begin
                    if (j_end)
                    begin
                        i_next     = '0;
                        j_next     = '0;
                        state_next = gji_pkg::ST_E_CHK;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = gji_pkg::ST_N_RD;
                    end
                end
            end
            gji_pkg::ST_E_CHK:
            begin
                if (i_reg == k_reg)
                begin
                    if (i_end)
                    begin
                        state_next = gji_pkg::ST_KNEXT;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = gji_pkg::ST_E_FR;
                end
            end
            gji_pkg::ST_E_FR:
            begin
                state_next = gji_pkg::ST_E_FL;
            end
            gji_pkg::ST_E_FL:
            begin
                state_next = gji_pkg::ST_E_RA;
            end
            gji_pkg::ST_E_RA:
            begin
                state_next = gji_pkg::ST_E_RB;
            end
            gji_pkg::ST_E_RB:
            begin
                state_next = gji_pkg::ST_E_M1;
            end
            gji_pkg::ST_E_M1:
            begin
                state_next = gji_pkg::ST_E_M2;
            end
            gji_pkg::ST_E_M2:
            begin
                state_next = gji_pkg::ST_E_W1;
            end
            gji_pkg::ST_E_W1:
            begin
                state_next = gji_pkg::ST_E_W2;
            end
            gji_pkg::ST_E_W2:
            begin
                if (!j_end)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = gji_pkg::ST_E_RA;
                end
                else
                begin
                    j_next = '0;
                    if (i_end)
                    begin
                        state_next = gji_pkg::ST_KNEXT;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = gji_pkg::ST_E_CHK;
                    end
                end
            end
            gji_pkg::ST_KNEXT:
            begin
                if (k_reg == nm1)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = gji_pkg::ST_O_RD;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = gji_pkg::ST_PIV_RD;
                end
            end
            gji_pkg::ST_O_RD:
            begin
                state_next = gji_pkg::ST_O_EM;
            end
            gji_pkg::ST_O_EM:
            begin
                if (j_end)
                begin
                    j_next = '0;
                    if (i_end)
                    begin
                        i_next     = '0;
                        state_next = gji_pkg::ST_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = gji_pkg::ST_O_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = gji_pkg::ST_O_RD;
                end
            end
            gji_pkg::ST_SING:
            begin
                i_next     = '0;
                j_next     = '0;
                state_next = gji_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = gji_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.wsel = gji_pkg::WSEL_SUB;
        unique case (state_reg)
            gji_pkg::ST_LOAD:
            begin
                cmd.row       = i_reg;
                cmd.col       = j_reg;
                cmd.we_w      = start & ~cfg_write;
                cmd.wsel      = gji_pkg::WSEL_LOAD;
                cmd.perm_init = 1'b1;
            end
            gji_pkg::ST_INIT:
            begin
                cmd.row  = i_reg;
                cmd.col  = j_reg;
                cmd.we_i = 1'b1;
                cmd.wsel = gji_pkg::WSEL_IDENT;
            end
            gji_pkg::ST_PIV_RD:
            begin
                cmd.row = k_reg;
                cmd.col = k_reg;
            end
            gji_pkg::ST_PIV_CHK, gji_pkg::ST_SRCH_CHK:
            begin
                cmd.lat_piv = 1'b1;
            end
            gji_pkg::ST_SRCH_RD:
            begin
                cmd.row = r_reg;
                cmd.col = k_reg;
            end
            gji_pkg::ST_SW0, gji_pkg::ST_SW2:
            begin
                cmd.row       = k_reg;
                cmd.perm_xchg = 1'b1;
            end
            gji_pkg::ST_SW1:
            begin
                cmd.row       = r_reg;
                cmd.perm_xchg = 1'b1;
            end
            gji_pkg::ST_N_RD:
            begin
                cmd.row = k_reg;
                cmd.col = j_reg;
            end
            gji_pkg::ST_N_LAT:
            begin
                cmd.lat_a = 1'b1;
            end
            gji_pkg::ST_N_SW:
            begin
                cmd.div_start = 1'b1;
            end
            gji_pkg::ST_N_WW:
            begin
                cmd.row       = k_reg;
                cmd.col       = j_reg;
                cmd.wsel      = gji_pkg::WSEL_DIV;
                cmd.we_w      = ~sts.div_busy;
                cmd.div_start = ~sts.div_busy;
                cmd.div_sel   = 1'b1;
            end
            gji_pkg::ST_N_WI:
            begin
                cmd.row  = k_reg;
                cmd.col  = j_reg;
                cmd.wsel = gji_pkg::WSEL_DIV;
                cmd.we_i = ~sts.div_busy;
            end
            gji_pkg::ST_E_FR:
            begin
                cmd.row = i_reg;
                cmd.col = k_reg;
            end
            gji_pkg::ST_E_FL:
            begin
                cmd.lat_f = 1'b1;
            end
            gji_pkg::ST_E_RA:
            begin
                cmd.row = k_reg;
                cmd.col = j_reg;
            end
            gji_pkg::ST_E_RB:
            begin
                cmd.lat_a = 1'b1;
                cmd.row   = i_reg;
                cmd.col   = j_reg;
            end
            gji_pkg::ST_E_M1:
            begin
                cmd.lat_b = 1'b1;
            end
            gji_pkg::ST_E_M2:
            begin
                cmd.mul_sel = 1'b1;
            end
            gji_pkg::ST_E_W1:
            begin
                cmd.row  = i_reg;
                cmd.col  = j_reg;
                cmd.we_w = 1'b1;
            end
            gji_pkg::ST_E_W2:
            begin
                cmd.row  = i_reg;
                cmd.col  = j_reg;
                cmd.we_i = 1'b1;
            end
            gji_pkg::ST_O_RD:
            begin
                cmd.row = i_reg;
                cmd.col = j_reg;
            end
            gji_pkg::ST_O_EM:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_last = i_end & j_end;
            end
            gji_pkg::ST_SING:
            begin
                cmd.emit_sing = 1'b1;
            end
            default:
            begin
                cmd.wsel = gji_pkg::WSEL_SUB;
            end
        endcase
    end

    assign busy = (state_reg != gji_pkg::ST_LOAD);

endmodule
